/* src/point_rotate_about_center_defines.svh */
// Assertion macros for the point rotation block.
// Used by point_rotate_about_center.sv; expects clk and rst in scope.
`ifndef POINT_ROTATE_ABOUT_CENTER_DEFINES_SVH
`define POINT_ROTATE_ABOUT_CENTER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define PRAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every clock edge, reset cycles included
`define PRAC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/prac_pkg.sv */
// Shared types, constants and helper functions for the point rotation block.
// No dependencies; imported by point_rotate_about_center.
`timescale 1ns / 1ps

package prac_pkg;

  localparam int FIELD_W             = 32;
  localparam int ANGLE_W             = 16;
  localparam int GUARD               = 8;
  localparam int ZW                  = 32;
  localparam int MAX_STAGES          = 32;
  localparam int QUARTER_SHIFT       = 14;
  localparam int DEF_ROTATION_STAGES = 16;
  localparam int DEF_COORD_BITS      = 32;

  localparam logic [ANGLE_W-1:0] EIGHTH_TURN = 16'h2000;

  // Exact quarter-turn pre-rotation
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        angle;
    logic signed [FIELD_W-1:0] center_x;
    logic signed [FIELD_W-1:0] center_y;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
  } prac_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] rotated_x;
    logic signed [FIELD_W-1:0] rotated_y;
    logic                      saturated;
  } prac_result_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ZW-1:0] ATAN_TAB [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Inverse CORDIC gain, unsigned Q0.32, for a given micro-rotation count
  function automatic logic [31:0] inv_gain(input int stages);
    int                 n;
    longint unsigned    d;
    n = (stages < 1) ? 1 : ((stages > MAX_STAGES) ? MAX_STAGES : stages);
    d = 64'd0;
    if (n < 16) begin
      d = (64'd1738754331 + (64'd1 << (2 * n - 1))) >> (2 * n);
    end
    return 32'(64'd2608131496 + d);
  endfunction

endpackage

/* src/point_rotate_about_center.sv */
// Rotates a point about a center by a binary angle, pipelined CORDIC.
// Depends on prac_pkg and point_rotate_about_center_defines.svh.
//
//   channel   beat type       handshake                 direction
//   item      prac_item_t     item_valid / item_stall   in
//   result    prac_result_t   result_valid / result_stall out
//
// Throughput is one beat per cycle while result_stall is low. Register stages: one
// for the quarter-turn pre-rotation, one per micro-rotation, then magnitude, gain
// multiply, rounding and center/clip.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage moves on when its successor is empty or moving, so bubbles
// collapse; item_stall rises only with every stage full and the result stalled.
`timescale 1ns / 1ps
`include "point_rotate_about_center_defines.svh"

module point_rotate_about_center
  import prac_pkg::*;
#(
  parameter int ROTATION_STAGES = DEF_ROTATION_STAGES,
  parameter int COORD_BITS      = DEF_COORD_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  prac_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output prac_result_t result
);

  localparam int N   = (ROTATION_STAGES < 1) ? 1 :
                       ((ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES);
  localparam int W   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DW  = W + GUARD + 3;
  localparam int MXW = (DW > 32) ? DW : 33;
  localparam int HW  = MXW - 32;
  localparam int MW  = W + 2;
  localparam int SW  = W + 3;
  localparam int T   = N + 5;
  localparam int S_ABS = N + 1;
  localparam int S_MUL = N + 2;
  localparam int S_RND = N + 3;
  localparam int S_OUT = N + 4;

  localparam logic [31:0] KINV = inv_gain(N);
  localparam logic signed [SW-1:0] SUM_HI = SW'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [SW-1:0] SUM_LO = SW'(-(longint'(1) <<< (W - 1)));

  // Stage valid bits and ready chain
  logic [T-1:0] vld;
  logic [T-1:0] vld_in;
  logic [T:0]   rdy;

  assign rdy[T]       = !result_stall;
  assign vld_in       = {vld[T-2:0], item_valid};
  assign item_stall   = !rdy[0];
  assign result_valid = vld[T-1];

  for (genvar s = 0; s < T; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < T; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld_in[s];
        end
      end
    end
  end

  // Pipeline payload
  logic signed [DW-1:0]    xr  [N+1];
  logic signed [DW-1:0]    yr  [N+1];
  logic signed [ZW-1:0]    zr  [N];
  logic signed [W-1:0]     ctr [2][T-1];
  logic signed [DW-1:0]    fin [2];
  logic                    sgn_a [2];
  logic [MXW-1:0]          mag_a [2];
  logic                    sgn_b [2];
  logic [63:0]             plo   [2];
  logic [HW+31:0]          phi   [2];
  logic                    sgn_c [2];
  logic [MW-1:0]           mag_c [2];
  logic signed [FIELD_W-1:0] rot [2];
  logic                    sat   [2];

  // Pre-rotation: quadrant split and operand swap for the differences
  logic signed [W-1:0]  cx_in, cy_in, px_in, py_in;
  logic signed [W-1:0]  xa, xb, ya, yb;
  logic signed [W:0]    x0, y0;
  logic [ANGLE_W:0]     a_sum;
  logic [2:0]           qf;
  quad_t                quad;
  logic [ANGLE_W:0]     resid;

  assign cx_in = $signed(item.center_x[W-1:0]);
  assign cy_in = $signed(item.center_y[W-1:0]);
  assign px_in = $signed(item.point_x[W-1:0]);
  assign py_in = $signed(item.point_y[W-1:0]);
  assign a_sum = {1'b0, item.angle} + {1'b0, EIGHTH_TURN};
  assign qf    = a_sum[ANGLE_W:QUARTER_SHIFT];
  assign quad  = quad_t'(qf[1:0]);
  assign resid = {1'b0, item.angle} - {qf, {QUARTER_SHIFT{1'b0}}};

  always_comb begin
    unique case (quad)
      QUAD_90: begin
        xa = cy_in; xb = py_in; ya = px_in; yb = cx_in;
      end
      QUAD_180: begin
        xa = cx_in; xb = px_in; ya = cy_in; yb = py_in;
      end
      QUAD_270: begin
        xa = py_in; xb = cy_in; ya = cx_in; yb = px_in;
      end
      default: begin
        xa = px_in; xb = cx_in; ya = py_in; yb = cy_in;
      end
    endcase
  end

  assign x0 = {xa[W-1], xa} - {xb[W-1], xb};
  assign y0 = {ya[W-1], ya} - {yb[W-1], yb};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      xr[0]     <= {{2{x0[W]}}, x0, {GUARD{1'b0}}};
      yr[0]     <= {{2{y0[W]}}, y0, {GUARD{1'b0}}};
      zr[0]     <= {resid[15:0], 16'h0000};
      ctr[0][0] <= cx_in;
      ctr[1][0] <= cy_in;
    end
  end

  // Carry the center along with its beat
  for (genvar s = 1; s < T - 1; s++) begin : g_ctr
    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        ctr[0][s] <= ctr[0][s-1];
        ctr[1][s] <= ctr[1][s-1];
      end
    end
  end

  // Micro-rotations, one register stage each
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [DW-1:0] xsh, ysh;
    logic                 neg;
    assign xsh = xr[i] >>> i;
    assign ysh = yr[i] >>> i;
    assign neg = zr[i][ZW-1];

    always_ff @(posedge clk) begin
      if (rdy[i+1]) begin
        if (!neg) begin
          xr[i+1] <= xr[i] - ysh;
          yr[i+1] <= yr[i] + xsh;
        end else begin
          xr[i+1] <= xr[i] + ysh;
          yr[i+1] <= yr[i] - xsh;
        end
      end
    end

    if (i + 1 < N) begin : g_z
      always_ff @(posedge clk) begin
        if (rdy[i+1]) begin
          zr[i+1] <= neg ? zr[i] + $signed(ATAN_TAB[i]) : zr[i] - $signed(ATAN_TAB[i]);
        end
      end
    end
  end

  assign fin[0] = xr[N];
  assign fin[1] = yr[N];

  // Gain compensation and center add, one lane per coordinate
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [DW-1:0]     fneg;
    logic [MXW:0]             acc;
    logic signed [SW-1:0]     cext;
    logic signed [SW-1:0]     mext;
    logic signed [SW-1:0]     sum;

    assign fneg = -fin[l];

    // Take magnitude and sign
    always_ff @(posedge clk) begin
      if (rdy[S_ABS]) begin
        sgn_a[l] <= fin[l][DW-1];
        mag_a[l] <= MXW'(unsigned'(fin[l][DW-1] ? fneg : fin[l]));
      end
    end

    // Multiply by inverse gain in two partial products
    always_ff @(posedge clk) begin
      if (rdy[S_MUL]) begin
        sgn_b[l] <= sgn_a[l];
        plo[l]   <= 64'(mag_a[l][31:0]) * 64'(KINV);
        phi[l]   <= (HW + 32)'(mag_a[l][MXW-1:32]) * (HW + 32)'(KINV);
      end
    end

    // Join partial products, drop guard bits rounding half up on magnitude
    assign acc = (MXW + 1)'(plo[l][63:32]) + (MXW + 1)'(phi[l]) +
                 (MXW + 1)'(1 << (GUARD - 1));

    always_ff @(posedge clk) begin
      if (rdy[S_RND]) begin
        sgn_c[l] <= sgn_b[l];
        mag_c[l] <= acc[GUARD +: MW];
      end
    end

    // Add the center back and clip to the coordinate range
    assign cext = SW'(ctr[l][T-2]);
    assign mext = $signed(SW'(mag_c[l]));
    assign sum  = sgn_c[l] ? cext - mext : cext + mext;

    always_ff @(posedge clk) begin
      if (rdy[S_OUT]) begin
        if (sum > SUM_HI) begin
          rot[l] <= FIELD_W'($signed(SUM_HI[W-1:0]));
          sat[l] <= 1'b1;
        end else if (sum < SUM_LO) begin
          rot[l] <= FIELD_W'($signed(SUM_LO[W-1:0]));
          sat[l] <= 1'b1;
        end else begin
          rot[l] <= FIELD_W'($signed(sum[W-1:0]));
          sat[l] <= 1'b0;
        end
      end
    end
  end

  assign result.rotated_x = rot[0];
  assign result.rotated_y = rot[1];
  assign result.saturated = sat[0] | sat[1];

  // A clipped beat must show at least one coordinate at a range limit
  logic at_limit;
  assign at_limit = (rot[0][W-1:0] == SUM_HI[W-1:0]) || (rot[0][W-1:0] == SUM_LO[W-1:0]) ||
                    (rot[1][W-1:0] == SUM_HI[W-1:0]) || (rot[1][W-1:0] == SUM_LO[W-1:0]);

  `PRAC_ASSERT_RST(a_reset_empties, rst |=> !result_valid && !item_stall, "pipeline not empty after reset")
  `PRAC_ASSERT(a_stall_only_full, item_stall |-> (&vld) && result_stall, "input stalled with a free stage")
  `PRAC_ASSERT(a_sat_at_limit, result_valid && result.saturated |-> at_limit, "saturated beat not at a limit")

endmodule
